// File: rtl/aob_pkg.sv
// ============================================================================
// aob_pkg
// Shared types and constants for the source-over alpha blend pipeline.
// ============================================================================
package aob_pkg;

    localparam int CHAN_W     = 8;
    localparam int COV_W      = 2 * CHAN_W;
    localparam int NUM_W      = 3 * CHAN_W;
    localparam int DIV_STEPS  = CHAN_W;
    localparam int NUM_LANES  = 3;
    localparam int STG_DIV0   = 2;
    localparam int STG_OUT    = STG_DIV0 + DIV_STEPS;
    localparam int PIPE_DEPTH = STG_OUT + 1;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [COV_W-1:0]  t_cov;
    typedef logic [NUM_W-1:0]  t_num;
    typedef logic [PIPE_DEPTH-1:0] t_stg_mask;
    typedef t_chan [NUM_LANES-1:0] t_chan_bus;
    typedef t_cov [DIV_STEPS-1:0]  t_den_taps;

    typedef struct packed {
        t_chan alpha;
        logic  den_zero;
    } t_cov_res;

    localparam t_chan CHAN_MAX = 8'd255;

endpackage

// File: rtl/aob_cover.sv
// ============================================================================
// aob_cover
// Coverage path: weighted coverage D, its per-stage copies, and output alpha.
// ============================================================================
module aob_cover (
    input  logic                i_clk,
    input  aob_pkg::t_stg_mask  i_load,
    input  aob_pkg::t_chan      i_src_alpha,
    input  aob_pkg::t_chan      i_dst_alpha,
    output aob_pkg::t_cov       o_wgt,
    output aob_pkg::t_den_taps  o_den,
    output aob_pkg::t_cov_res   o_res
);
    import aob_pkg::*;

    t_cov             r_asx;
    t_cov             r_wgt;
    t_cov             r_den   [DIV_STEPS+1];
    t_chan            r_alpha [DIV_STEPS+1];
    t_cov             n_den;
    logic [COV_W:0]   n_alpha_sum;

    // D = As*255 + Ad*(255-As); alpha = D/255 by the exact 16-bit identity.
    always_comb begin
        n_den       = r_asx + r_wgt;
        n_alpha_sum = {1'b0, n_den} + (COV_W+1)'(1) + (COV_W+1)'(n_den >> CHAN_W);
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_asx <= t_cov'({i_src_alpha, CHAN_W'(0)}) - t_cov'(i_src_alpha);
            r_wgt <= t_cov'(i_dst_alpha) * t_cov'(CHAN_MAX - i_src_alpha);
        end
        if (i_load[1]) begin
            r_den[0]   <= n_den;
            r_alpha[0] <= n_alpha_sum[2*CHAN_W-1:CHAN_W];
        end
        for (int i = 1; i <= DIV_STEPS; i++) begin
            if (i_load[1+i]) begin
                r_den[i]   <= r_den[i-1];
                r_alpha[i] <= r_alpha[i-1];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < DIV_STEPS; j++) begin
            o_den[j] = r_den[j];
        end
    end

    assign o_wgt          = r_wgt;
    assign o_res.alpha    = r_alpha[DIV_STEPS];
    assign o_res.den_zero = (r_den[DIV_STEPS] == '0);

endmodule

// File: rtl/aob_lane.sv
// ============================================================================
// aob_lane
// One color lane: weighted numerator and an eight-stage restoring divider.
// ============================================================================
module aob_lane (
    input  logic                i_clk,
    input  aob_pkg::t_stg_mask  i_load,
    input  aob_pkg::t_chan      i_src_chan,
    input  aob_pkg::t_chan      i_dst_chan,
    input  aob_pkg::t_chan      i_src_alpha,
    input  aob_pkg::t_cov       i_wgt,
    input  aob_pkg::t_den_taps  i_den,
    output aob_pkg::t_chan      o_quo
);
    import aob_pkg::*;

    t_cov  r_csa;
    t_chan r_cd;
    t_num  r_num;
    t_num  r_rem [DIV_STEPS];
    t_chan r_quo [DIV_STEPS];
    t_num  n_num;
    t_num  n_rem [DIV_STEPS];
    t_chan n_quo [DIV_STEPS];

    // Numerator Cs*As*255 + Cd*Ad*(255-As); it never exceeds 255*D.
    assign n_num = (t_num'(r_csa) << CHAN_W) - t_num'(r_csa)
                 + t_num'(r_cd) * t_num'(i_wgt);

    // Each stage settles one quotient bit, most significant first.
    always_comb begin
        t_num  v_rem_in;
        t_num  v_sub;
        t_chan v_quo_in;
        for (int j = 0; j < DIV_STEPS; j++) begin
            v_rem_in = (j == 0) ? r_num : r_rem[(j == 0) ? 0 : j-1];
            v_quo_in = (j == 0) ? '0    : r_quo[(j == 0) ? 0 : j-1];
            v_sub    = t_num'(i_den[j]) << (DIV_STEPS - 1 - j);
            if (v_rem_in >= v_sub) begin
                n_rem[j] = v_rem_in - v_sub;
                n_quo[j] = {v_quo_in[CHAN_W-2:0], 1'b1};
            end else begin
                n_rem[j] = v_rem_in;
                n_quo[j] = {v_quo_in[CHAN_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_csa <= t_cov'(i_src_chan) * t_cov'(i_src_alpha);
            r_cd  <= i_dst_chan;
        end
        if (i_load[1]) begin
            r_num <= n_num;
        end
        for (int j = 0; j < DIV_STEPS; j++) begin
            if (i_load[STG_DIV0+j]) begin
                r_rem[j] <= n_rem[j];
                r_quo[j] <= n_quo[j];
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS-1];

endmodule

// File: rtl/aob_merge.sv
// ============================================================================
// aob_merge
// Output register: joins the lane quotients with the coverage result.
// ============================================================================
module aob_merge (
    input  logic                i_clk,
    input  logic                i_load,
    input  aob_pkg::t_chan_bus  i_quo,
    input  aob_pkg::t_cov_res   i_res,
    output aob_pkg::t_chan      o_alpha,
    output aob_pkg::t_chan      o_red,
    output aob_pkg::t_chan      o_green,
    output aob_pkg::t_chan      o_blue
);
    import aob_pkg::*;

    t_chan r_alpha;
    t_chan r_red;
    t_chan r_green;
    t_chan r_blue;

    // With zero coverage the divider saturates, so the colors are forced to zero.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_alpha <= i_res.alpha;
            r_red   <= i_res.den_zero ? '0 : i_quo[LANE_RED];
            r_green <= i_res.den_zero ? '0 : i_quo[LANE_GREEN];
            r_blue  <= i_res.den_zero ? '0 : i_quo[LANE_BLUE];
        end
    end

    assign o_alpha = r_alpha;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

// File: rtl/alpha_over_blend_core.sv
// ============================================================================
// alpha_over_blend_core
// Source-over compositing of one ARGB8888 pixel pair per transaction.
// ============================================================================
// The input channel carries a source and a destination pixel; a transaction
// completes when i_in_valid and o_in_ready are both high at a rising edge.
// The output channel carries the composite pixel under o_out_valid and
// i_out_ready in the same way. Every input transaction yields exactly one
// output transaction, in order.
// The block is an eleven-stage pipeline: a product stage, a numerator stage,
// eight divider stages (one quotient bit each, set by the per-lane restoring
// divider) and the output register. A result moves through these stages in
// order and waits in the output register until the receiver takes it.
// Throughput is one pixel pair per clock while the receiver keeps up.
// Each stage holds its data only while the stage after it is full and stuck,
// so bubbles close up and up to eleven transactions can be in flight; while
// the receiver stalls, new inputs are still taken until every stage is full.
// Synchronous reset empties the pipeline; payload registers are not reset.
// ============================================================================
module alpha_over_blend_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  aob_pkg::t_chan  i_src_alpha,
    input  aob_pkg::t_chan  i_src_red,
    input  aob_pkg::t_chan  i_src_green,
    input  aob_pkg::t_chan  i_src_blue,
    input  aob_pkg::t_chan  i_dst_alpha,
    input  aob_pkg::t_chan  i_dst_red,
    input  aob_pkg::t_chan  i_dst_green,
    input  aob_pkg::t_chan  i_dst_blue,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output aob_pkg::t_chan  o_out_alpha,
    output aob_pkg::t_chan  o_out_red,
    output aob_pkg::t_chan  o_out_green,
    output aob_pkg::t_chan  o_out_blue
);
    import aob_pkg::*;

    t_stg_mask r_vld;
    t_stg_mask n_vld;
    t_stg_mask w_free;
    t_stg_mask w_src_vld;
    t_stg_mask w_load;
    t_chan_bus w_src_chan;
    t_chan_bus w_dst_chan;
    t_chan_bus w_quo;
    t_cov      w_wgt;
    t_den_taps w_den;
    t_cov_res  w_res;

    // A stage is free when it is empty or when its contents move on this cycle.
    always_comb begin
        w_free[PIPE_DEPTH-1] = !r_vld[PIPE_DEPTH-1] || i_out_ready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
            w_free[i] = !r_vld[i] || w_free[i+1];
        end
    end

    assign w_src_vld = {r_vld[PIPE_DEPTH-2:0], i_in_valid};
    assign w_load    = w_src_vld & w_free;
    // A free stage takes whatever its source offers; a stuck stage stays full.
    assign n_vld     = (w_free & w_src_vld) | (~w_free & r_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = w_free[0];
    assign o_out_valid = r_vld[PIPE_DEPTH-1];

    assign w_src_chan[LANE_RED]   = i_src_red;
    assign w_src_chan[LANE_GREEN] = i_src_green;
    assign w_src_chan[LANE_BLUE]  = i_src_blue;
    assign w_dst_chan[LANE_RED]   = i_dst_red;
    assign w_dst_chan[LANE_GREEN] = i_dst_green;
    assign w_dst_chan[LANE_BLUE]  = i_dst_blue;

    // Coverage path shared by all color lanes.
    aob_cover u_cover (
        .i_clk       (i_clk),
        .i_load      (w_load),
        .i_src_alpha (i_src_alpha),
        .i_dst_alpha (i_dst_alpha),
        .o_wgt       (w_wgt),
        .o_den       (w_den),
        .o_res       (w_res)
    );

    // One lane per color channel, running side by side.
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        aob_lane u_lane (
            .i_clk       (i_clk),
            .i_load      (w_load),
            .i_src_chan  (w_src_chan[g]),
            .i_dst_chan  (w_dst_chan[g]),
            .i_src_alpha (i_src_alpha),
            .i_wgt       (w_wgt),
            .i_den       (w_den),
            .o_quo       (w_quo[g])
        );
    end

    aob_merge u_merge (
        .i_clk   (i_clk),
        .i_load  (w_load[STG_OUT]),
        .i_quo   (w_quo),
        .i_res   (w_res),
        .o_alpha (o_out_alpha),
        .o_red   (o_out_red),
        .o_green (o_out_green),
        .o_blue  (o_out_blue)
    );

endmodule

// File: rtl/aob_checker.sv
// ============================================================================
// aob_checker
// Port-level checks on the blend core, attached by a bind statement.
// ============================================================================
module aob_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            o_in_ready,
    input  logic            o_out_valid,
    input  logic            i_out_ready,
    input  aob_pkg::t_chan  o_out_alpha,
    input  aob_pkg::t_chan  o_out_red,
    input  aob_pkg::t_chan  o_out_green,
    input  aob_pkg::t_chan  o_out_blue
);
    import aob_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic             w_in_xfer;
    logic             w_out_xfer;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_xfer = o_out_valid && i_out_ready;

    // Number of transactions accepted but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_in_xfer && !w_out_xfer) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (!w_in_xfer && w_out_xfer) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_alpha)
            && $stable(o_out_red) && $stable(o_out_green) && $stable(o_out_blue))
        else $error("output transaction changed while stalled");

    a_ready_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input not ready although the output side can drain");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer |-> r_cnt != '0)
        else $error("output transaction without a pending input");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(PIPE_DEPTH))
        else $error("more transactions in flight than pipeline stages");

endmodule

bind alpha_over_blend_core aob_checker u_aob_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_alpha (o_out_alpha),
    .o_out_red   (o_out_red),
    .o_out_green (o_out_green),
    .o_out_blue  (o_out_blue)
);
